// ----- sv/hcsc_pkg.sv -----
package hcsc_pkg;

    // Fraction bits of the fixed-point constants.
    localparam int FRAC_BITS = 16;

    // Width of the constants and of the products with the pixel offsets.
    localparam int KW = FRAC_BITS;
    localparam int PW = FRAC_BITS + 14;

    // Width of the fractional cube coordinates and their shift to an integer.
    localparam int FW    = FRAC_BITS + 33;
    localparam int SH    = FRAC_BITS + 16;
    localparam int CW    = FW - SH;
    localparam int ERR_W = SH + 1;

    // Depth of the queue between the converter and the clamp walk.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Integer square root, used only to derive the constants below.
    function automatic logic [63:0] isqrt_c(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bits;
        n    = n_in;
        res  = 64'd0;
        bits = 64'd1 << 62;
        while (bits > n) bits = bits >> 2;
        while (bits != 64'd0) begin
            if (n >= res + bits) begin
                n   = n - (res + bits);
                res = (res >> 1) + bits;
            end else begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    // sqrt(3)/3, 1/3 and 2/3, each rounded to nearest.
    localparam logic [63:0] ONE_F = 64'd1 << FRAC_BITS;
    localparam logic [63:0] K3_64 =
        (isqrt_c((64'd1 << (2 * FRAC_BITS + 2)) / 64'd3) + 64'd1) >> 1;
    localparam logic [63:0] K1_64 = (ONE_F + 64'd1) / 64'd3;
    localparam logic [63:0] K2_64 = (64'd2 * ONE_F + 64'd1) / 64'd3;

    localparam logic [KW-1:0] K3 = K3_64[KW-1:0];
    localparam logic [KW-1:0] K1 = K1_64[KW-1:0];
    localparam logic [KW-1:0] K2 = K2_64[KW-1:0];

    // One rounded cube coordinate triple.
    typedef struct packed {
        logic signed [CW-1:0] q;
        logic signed [CW-1:0] r;
        logic signed [CW-1:0] s;
    } t_cube;

endpackage

// ----- sv/hcsc_front.sv -----
module hcsc_front
    import hcsc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  logic [11:0]   i_cursor_x,
    input  logic [11:0]   i_cursor_y,
    input  logic [11:0]   i_center_x,
    input  logic [11:0]   i_center_y,
    input  logic [16:0]   i_inv_radius,
    output logic          o_q_push,
    input  logic          i_q_full,
    output t_cube         o_q_data
);

    typedef struct packed {
        logic signed [CW-1:0] val;
        logic [ERR_W-1:0]     err;
    } t_rnd;

    localparam logic signed [KW:0]   K3S    = {1'b0, K3};
    localparam logic signed [KW:0]   K1S    = {1'b0, K1};
    localparam logic signed [KW:0]   K2S    = {1'b0, K2};
    localparam logic [ERR_W-1:0]     UNIT_E = {1'b1, {SH{1'b0}}};

    // Round half away from zero; the error against the exact value is
    // the fraction, or its complement when the magnitude was rounded up.
    function automatic t_rnd round_haz(input logic signed [FW-1:0] v);
        logic [FW-1:0] mag;
        logic [SH-1:0] frac;
        logic [CW-1:0] n;
        t_rnd          res;
        mag  = v[FW-1] ? FW'(-v) : FW'(v);
        frac = mag[SH-1:0];
        n    = mag[FW-1:SH] + {{(CW-1){1'b0}}, frac[SH-1]};
        res.val = v[FW-1] ? -$signed(n) : $signed(n);
        res.err = frac[SH-1] ? (UNIT_E - {1'b0, frac}) : {1'b0, frac};
        return res;
    endfunction

    logic [5:1]                  r_v;
    logic                        w_en;
    logic signed [12:0]          r_x;
    logic signed [12:0]          r_y;
    logic signed [PW-1:0]        r_px;
    logic signed [PW-1:0]        r_py1;
    logic signed [PW-1:0]        r_py2;
    logic signed [PW:0]          w_diff;
    logic signed [PW:0]          w_ry;
    logic signed [17:0]          w_inv;
    logic signed [FW-1:0]        r_fq3;
    logic signed [FW-1:0]        r_fr3;
    logic signed [FW-1:0]        r_fq4;
    logic signed [FW-1:0]        r_fr4;
    logic signed [FW-1:0]        r_fs4;
    t_rnd                        r_rq;
    t_rnd                        r_rr;
    t_rnd                        r_rs;
    t_cube                       w_fix;

    // The pipeline moves unless its last stage holds an item the queue cannot take.
    assign w_en     = !(r_v[5] && i_q_full);
    assign o_full   = !w_en;
    assign o_q_push = r_v[5] && !i_q_full;

    assign w_diff = {r_px[PW-1], r_px} - {r_py1[PW-1], r_py1};
    assign w_ry   = {r_py2[PW-1], r_py2};
    assign w_inv  = {1'b0, i_inv_radius};

    // Valid bits of the five stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[4:1], i_push};
        end
    end

    // Offsets, constant products, reciprocal products, s, then rounding.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x   <= $signed({1'b0, i_cursor_x}) - $signed({1'b0, i_center_x});
            r_y   <= $signed({1'b0, i_cursor_y}) - $signed({1'b0, i_center_y});
            r_px  <= K3S * r_x;
            r_py1 <= K1S * r_y;
            r_py2 <= K2S * r_y;
            r_fq3 <= w_diff * w_inv;
            r_fr3 <= w_ry * w_inv;
            r_fq4 <= r_fq3;
            r_fr4 <= r_fr3;
            r_fs4 <= -r_fq3 - r_fr3;
            r_rq  <= round_haz(r_fq4);
            r_rr  <= round_haz(r_fr4);
            r_rs  <= round_haz(r_fs4);
        end
    end

    // Rebuild the coordinate with the largest rounding error from the other two.
    always_comb begin
        w_fix.q = r_rq.val;
        w_fix.r = r_rr.val;
        w_fix.s = r_rs.val;
        priority if (r_rq.err > r_rr.err && r_rq.err > r_rs.err) begin
            w_fix.q = -r_rr.val - r_rs.val;
        end else if (r_rr.err > r_rs.err) begin
            w_fix.r = -r_rq.val - r_rs.val;
        end else begin
            w_fix.s = -r_rq.val - r_rr.val;
        end
    end

    assign o_q_data = w_fix;

endmodule

// ----- sv/hcsc_fifo.sv -----
module hcsc_fifo
    import hcsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    output logic    o_full,
    input  t_cube   i_data,
    input  logic    i_pop,
    output logic    o_empty,
    output t_cube   o_data
);

    t_cube               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wr_ptr;
    logic [FIFO_AW-1:0]  r_rd_ptr;
    logic [FIFO_AW:0]    r_count;
    logic                w_wr;
    logic                w_rd;

    assign o_full  = (r_count == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + (FIFO_AW + 1)'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - (FIFO_AW + 1)'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/hcsc_clamp.sv -----
module hcsc_clamp
    import hcsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    output logic               o_q_pop,
    input  t_cube              i_q_data,
    input  logic [6:0]         i_grid_radius,
    output logic               o_empty,
    input  logic               i_pop,
    output logic signed [13:0] o_hex_q,
    output logic signed [13:0] o_hex_r,
    output logic signed [13:0] o_hex_s,
    output logic               o_was_inside
);

    typedef enum logic {ST_IDLE, ST_WALK} t_state;

    t_state                r_state;
    logic signed [CW-1:0]  r_q;
    logic signed [CW-1:0]  r_r;
    logic signed [CW-1:0]  r_s;
    logic                  r_first;
    logic                  r_inside;
    logic                  r_out_valid;
    logic signed [13:0]    r_hex_q;
    logic signed [13:0]    r_hex_r;
    logic signed [13:0]    r_hex_s;
    logic                  r_was_inside;

    logic [CW-1:0]         w_aq;
    logic [CW-1:0]         w_ar;
    logic [CW-1:0]         w_as;
    logic [CW+1:0]         w_sum;
    logic [CW:0]           w_dist;
    logic [6:0]            w_limit;
    logic                  w_done;
    logic                  w_out_free;
    logic                  w_emit;
    logic signed [CW-1:0]  n_q;
    logic signed [CW-1:0]  n_r;
    logic signed [CW-1:0]  n_s;

    function automatic logic [CW-1:0] abs_c(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    function automatic logic signed [CW-1:0] toward_zero(input logic signed [CW-1:0] v);
        return v[CW-1] ? (v + {{(CW-1){1'b0}}, 1'b1}) : (v - {{(CW-1){1'b0}}, 1'b1});
    endfunction

    // Distance from the origin and the bound of the inner region.
    assign w_aq    = abs_c(r_q);
    assign w_ar    = abs_c(r_r);
    assign w_as    = abs_c(r_s);
    assign w_sum   = {2'b00, w_aq} + {2'b00, w_ar} + {2'b00, w_as};
    assign w_dist  = w_sum[CW+1:1];
    assign w_limit = ((i_grid_radius < 7'd2) ? 7'd2 : i_grid_radius) - 7'd1;
    assign w_done  = (w_dist < (CW + 1)'(w_limit));

    assign w_out_free = !r_out_valid || i_pop;
    assign w_emit     = (r_state == ST_WALK) && w_done && w_out_free;
    assign o_q_pop    = (r_state == ST_IDLE) && !i_q_empty;

    // One unit step: the largest and second largest magnitudes move toward zero.
    always_comb begin
        n_q = r_q;
        n_r = r_r;
        n_s = r_s;
        priority if (w_aq > w_ar && w_aq > w_as) begin
            n_q = toward_zero(r_q);
            if (w_ar > w_as) n_r = toward_zero(r_r);
            else             n_s = toward_zero(r_s);
        end else if (w_ar > w_as) begin
            n_r = toward_zero(r_r);
            if (w_aq > w_as) n_q = toward_zero(r_q);
            else             n_s = toward_zero(r_s);
        end else begin
            n_s = toward_zero(r_s);
            if (w_aq > w_ar) n_q = toward_zero(r_q);
            else             n_r = toward_zero(r_r);
        end
    end

    // Walk sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result refills the register even when the old one leaves now.
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_q     <= i_q_data.q;
                        r_r     <= i_q_data.r;
                        r_s     <= i_q_data.s;
                        r_first <= 1'b1;
                        r_state <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    r_first <= 1'b0;
                    if (r_first) begin
                        r_inside <= w_done;
                    end
                    if (w_done) begin
                        if (w_out_free) begin
                            r_hex_q      <= r_q[13:0];
                            r_hex_r      <= r_r[13:0];
                            r_hex_s      <= r_s[13:0];
                            r_was_inside <= r_first ? w_done : r_inside;
                            r_state      <= ST_IDLE;
                        end
                    end else begin
                        r_q <= n_q;
                        r_r <= n_r;
                        r_s <= n_s;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_hex_q      = r_hex_q;
    assign o_hex_r      = r_hex_r;
    assign o_hex_s      = r_hex_s;
    assign o_was_inside = r_was_inside;

endmodule

// ----- sv/hex_cursor_select_clamp.sv -----
// Channel    Transfer when       Payload
// input      push && !full       i_cursor_x, i_cursor_y
// result     pop && !empty       o_hex_q, o_hex_r, o_hex_s, o_was_inside
// config     i_cfg_we            i_cfg_idx, i_cfg_data
//
// A five-stage converter turns a cursor pixel into a rounded cube coordinate
// and hands it to a four-entry queue; the clamp walk then loads it in its idle
// state and moves it one unit step at a time until it lies in the inner region,
// and takes the next item from the queue only after its result is written.
// Reset is synchronous and clears all valid bits, pointers and states.
// A result waiting on a stalled pop holds the walk only when the next item is done.
module hex_cursor_select_clamp
    import hcsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [11:0]        i_cursor_x,
    input  logic [11:0]        i_cursor_y,
    output logic               empty,
    input  logic               pop,
    output logic signed [13:0] o_hex_q,
    output logic signed [13:0] o_hex_r,
    output logic signed [13:0] o_hex_s,
    output logic               o_was_inside,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [16:0]        i_cfg_data
);

    localparam logic [1:0] REG_CENTER_X    = 2'd0;
    localparam logic [1:0] REG_CENTER_Y    = 2'd1;
    localparam logic [1:0] REG_INV_RADIUS  = 2'd2;
    localparam logic [1:0] REG_GRID_RADIUS = 2'd3;

    logic [11:0]  r_center_x;
    logic [11:0]  r_center_y;
    logic [16:0]  r_inv_radius;
    logic [6:0]   r_grid_radius;

    logic         w_q_push;
    logic         w_q_full;
    logic         w_q_pop;
    logic         w_q_empty;
    t_cube        w_q_wdata;
    t_cube        w_q_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x    <= 12'd0;
            r_center_y    <= 12'd0;
            r_inv_radius  <= 17'd65536;
            r_grid_radius <= 7'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CENTER_X:    r_center_x    <= i_cfg_data[11:0];
                REG_CENTER_Y:    r_center_y    <= i_cfg_data[11:0];
                REG_INV_RADIUS:  r_inv_radius  <= i_cfg_data;
                REG_GRID_RADIUS: r_grid_radius <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Pixel to rounded cube coordinate.
    hcsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cursor_x   (i_cursor_x),
        .i_cursor_y   (i_cursor_y),
        .i_center_x   (r_center_x),
        .i_center_y   (r_center_y),
        .i_inv_radius (r_inv_radius),
        .o_q_push     (w_q_push),
        .i_q_full     (w_q_full),
        .o_q_data     (w_q_wdata)
    );

    // Queue between converter and clamp walk.
    hcsc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .o_full  (w_q_full),
        .i_data  (w_q_wdata),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_rdata)
    );

    // Clamp into the inner region.
    hcsc_clamp u_clamp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_q_empty),
        .o_q_pop       (w_q_pop),
        .i_q_data      (w_q_rdata),
        .i_grid_radius (r_grid_radius),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_hex_q       (o_hex_q),
        .o_hex_r       (o_hex_r),
        .o_hex_s       (o_hex_s),
        .o_was_inside  (o_was_inside)
    );

endmodule
